>>> src/mqtt_inbound_packet_parser_defines.svh
// Assertion macros used by the checker file of the MQTT inbound parser.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef MQTT_INBOUND_PACKET_PARSER_DEFINES_SVH
`define MQTT_INBOUND_PACKET_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MQP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled during reset
`define MQP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> src/mqttp_pkg.sv
// Shared types and constants for the MQTT inbound packet parser.
// No dependencies; imported by the parser core, the top level, the checker and the testbench.
package mqttp_pkg;

  localparam int MAX_LENGTH_BYTES = 4;  // remaining-length bytes allowed, 1..4

  localparam logic [15:0] MAX_PKT_RESET = 16'd128;

  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PINGREQ  = 4'd12;
  localparam logic [3:0] TYPE_PINGRESP = 4'd13;

  // configuration register indexes
  localparam logic REG_MAX_PKT = 1'b0;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    EV_TOPIC    = 3'd0,
    EV_PAYLOAD  = 3'd1,
    EV_PINGREQ  = 3'd2,
    EV_PINGRESP = 3'd3,
    EV_DROP     = 3'd4,
    EV_OTHER    = 3'd5
  } ev_t;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

>>> src/mqttp_core.sv
// Framing state machine of the MQTT inbound parser: one byte per step.
// Depends on mqttp_pkg.
module mqttp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic [7:0]        data_i,
  input  logic [15:0]       max_bytes_i,
  output logic              emit_o,
  output mqttp_pkg::res_t   res_o
);
  import mqttp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [27:0] rc_r, rc_nxt;
  logic [1:0]  ls_r, ls_nxt;
  logic [15:0] tr_r, tr_nxt;
  logic        drop_r, drop_nxt;

  logic [27:0] rc_acc;
  logic [27:0] rc_dec;
  logic [15:0] tr_dec;
  logic [15:0] tr_lo;
  logic [28:0] total;
  logic        len_full;

  function automatic ev_t end_event(input logic [3:0] t);
    if (t == TYPE_PINGREQ) return EV_PINGREQ;
    if (t == TYPE_PINGRESP) return EV_PINGRESP;
    return EV_OTHER;
  endfunction

  always_comb begin
    unique case (ls_r)
      2'd0: rc_acc = rc_r | {21'b0, data_i[6:0]};
      2'd1: rc_acc = rc_r | {14'b0, data_i[6:0], 7'b0};
      2'd2: rc_acc = rc_r | {7'b0, data_i[6:0], 14'b0};
      2'd3: rc_acc = rc_r | {data_i[6:0], 21'b0};
    endcase
  end

  assign rc_dec   = rc_r - 28'd1;
  assign tr_dec   = tr_r - 16'd1;
  assign tr_lo    = tr_r | {8'b0, data_i};
  assign total    = 29'd2 + {27'b0, ls_r} + {1'b0, rc_acc};
  assign len_full = ({1'b0, ls_r} + 3'd1) >= 3'(MAX_LENGTH_BYTES);

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    rc_nxt    = rc_r;
    ls_nxt    = ls_r;
    tr_nxt    = tr_r;
    drop_nxt  = drop_r;
    emit_o    = 1'b0;
    res_o     = '{ev: EV_OTHER, data: 8'd0, last: 1'b1};
    if (step_i) begin
      unique case (phase_r)
        PH_HEADER: begin
          type_nxt  = data_i[7:4];
          rc_nxt    = '0;
          ls_nxt    = '0;
          tr_nxt    = '0;
          drop_nxt  = 1'b0;
          phase_nxt = PH_LENGTH;
        end
        PH_LENGTH: begin
          rc_nxt = rc_acc;
          if (data_i[7]) begin
            if (len_full) begin
              phase_nxt = PH_HEADER;
              emit_o    = 1'b1;
              res_o.ev  = EV_DROP;
            end else begin
              ls_nxt = ls_r + 2'd1;
            end
          end else if (total > {13'b0, max_bytes_i}) begin
            drop_nxt  = 1'b1;
            phase_nxt = (rc_acc == '0) ? PH_HEADER : PH_SKIP;
            emit_o    = 1'b1;
            res_o.ev  = EV_DROP;
          end else if (type_r == TYPE_PUBLISH) begin
            if (rc_acc < 28'd2) begin
              // body too short for the topic length
              drop_nxt  = 1'b1;
              phase_nxt = (rc_acc == '0) ? PH_HEADER : PH_SKIP;
              emit_o    = 1'b1;
              res_o.ev  = EV_DROP;
            end else begin
              phase_nxt = PH_TLEN_HI;
            end
          end else if (rc_acc == '0) begin
            phase_nxt = PH_HEADER;
            emit_o    = 1'b1;
            res_o.ev  = end_event(type_r);
          end else begin
            drop_nxt  = 1'b0;
            phase_nxt = PH_SKIP;
          end
        end
        PH_TLEN_HI: begin
          tr_nxt    = {data_i, 8'b0};
          rc_nxt    = rc_dec;
          phase_nxt = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          tr_nxt = tr_lo;
          rc_nxt = rc_dec;
          if ({12'b0, tr_lo} > rc_dec) begin
            drop_nxt  = 1'b1;
            phase_nxt = (rc_dec == '0) ? PH_HEADER : PH_SKIP;
            emit_o    = 1'b1;
            res_o.ev  = EV_DROP;
          end else if (tr_lo != '0) begin
            phase_nxt = PH_TOPIC;
          end else if (rc_dec != '0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = PH_HEADER;
            emit_o    = 1'b1;
            res_o.ev  = EV_OTHER;
          end
        end
        PH_TOPIC: begin
          tr_nxt = tr_dec;
          rc_nxt = rc_dec;
          if (tr_dec == '0)
            phase_nxt = (rc_dec == '0) ? PH_HEADER : PH_PAYLOAD;
          emit_o     = 1'b1;
          res_o.ev   = EV_TOPIC;
          res_o.data = data_i;
          res_o.last = (rc_dec == '0);
        end
        PH_PAYLOAD: begin
          rc_nxt = rc_dec;
          if (rc_dec == '0) phase_nxt = PH_HEADER;
          emit_o     = 1'b1;
          res_o.ev   = EV_PAYLOAD;
          res_o.data = data_i;
          res_o.last = (rc_dec == '0);
        end
        PH_SKIP: begin
          rc_nxt = rc_dec;
          if (rc_dec == '0) begin
            phase_nxt = PH_HEADER;
            drop_nxt  = 1'b0;
            // dropped packets already reported their event
            emit_o    = !drop_r;
            res_o.ev  = end_event(type_r);
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      type_r  <= '0;
      rc_r    <= '0;
      ls_r    <= '0;
      tr_r    <= '0;
      drop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      rc_r    <= rc_nxt;
      ls_r    <= ls_nxt;
      tr_r    <= tr_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule

>>> src/mqtt_inbound_packet_parser.sv
// MQTT inbound packet parser, QoS 0: takes one stream byte per request and
// frames fixed header, remaining length, PUBLISH topic and payload, and pings.
// Rate: one byte per clock while out_ready keeps the output register free; each
// byte passes an input register, then the combinational core, and leaves its result
// (if any) in the output register. The only loop is the framing state update in
// mqttp_core. No clearing pass follows reset.
// Depends on mqttp_pkg and mqttp_core.
module mqtt_inbound_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  // results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_out_byte,
  output logic        out_last,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mqttp_pkg::*;

  logic [15:0] max_pkt_r;
  logic        in_valid_r;
  logic [7:0]  in_data_r;
  logic        out_valid_r;
  res_t        out_res_r;

  logic        adv;
  logic        step;
  logic        emit;
  res_t        res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PKT) ? {16'b0, max_pkt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pkt_r <= MAX_PKT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PKT)) begin
      max_pkt_r <= pwdata[15:0];
    end
  end

  // the core advances whenever the output register can take a result
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;
  assign step     = in_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) in_data_r <= in_data_byte;
  end

  mqttp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .data_i      (in_data_r),
    .max_bytes_i (max_pkt_r),
    .emit_o      (emit),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_res_r <= res;
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_res_r.ev;
  assign out_out_byte  = out_res_r.data;
  assign out_last      = out_res_r.last;

endmodule

>>> src/mqttp_checker.sv
// Port-level checks for the MQTT inbound parser, bound to the top level.
// Depends on mqttp_pkg and mqtt_inbound_packet_parser_defines.svh.
`include "mqtt_inbound_packet_parser_defines.svh"

module mqttp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_res,
  input logic [7:0] out_out_byte,
  input logic       out_last
);
  import mqttp_pkg::*;

  // a stalled result holds
  `MQP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_out_byte) && $stable(out_last))

  `MQP_ASSERT_NOW(a_ev_range, out_valid, out_event_res <= EV_OTHER)

  // only topic and payload events carry a byte
  `MQP_ASSERT_NOW(a_byte_zero, out_valid && (out_event_res != EV_TOPIC) && (out_event_res != EV_PAYLOAD), out_out_byte == 8'd0)

  // ping, drop and end events always close the packet
  `MQP_ASSERT_NOW(a_end_last, out_valid && (out_event_res >= EV_PINGREQ), out_last)

endmodule

bind mqtt_inbound_packet_parser mqttp_checker u_mqttp_checker (.*);

>>> verif/mqtt_inbound_packet_parser_tb.sv
// Self-checking testbench for mqtt_inbound_packet_parser: directed and random byte streams,
// with a cycle-free frame predictor and an in-order event check.
// Depends on mqttp_pkg and the parser RTL only.
module mqtt_inbound_packet_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mqttp_pkg::*;

  localparam logic [2:0] MAX_PKT_ADDR = {REG_MAX_PKT, 2'b00};
  localparam int DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_res;
  logic [7:0]  out_out_byte;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mqtt_inbound_packet_parser u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_out_byte  (out_out_byte),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // frame predictor state
  phase_t      frame_ph;
  logic [3:0]  pkt_type;
  logic [27:0] rem_cnt;
  logic [1:0]  len_idx;
  logic [15:0] topic_left;
  logic        drop_pkt;
  logic [15:0] max_pkt;

  res_t pending_events[$];
  res_t head_event;
  res_t next_event;

  int send_gap_pct;
  int recv_stall_pct;
  int bytes_in;
  int results_seen;
  int mismatch_count;
  int ev_count[6];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ev_t end_event();
    if (pkt_type == TYPE_PINGREQ) return EV_PINGREQ;
    if (pkt_type == TYPE_PINGRESP) return EV_PINGRESP;
    return EV_OTHER;
  endfunction

  function automatic void enter_skip(input logic drop);
    drop_pkt = drop;
    if (rem_cnt == 0) frame_ph = PH_HEADER;
    else frame_ph = PH_SKIP;
  endfunction

  // Advances the framer by one stream byte; returns 1 when an event is due.
  function automatic bit frame_byte(input logic [7:0] b, output res_t r);
    int unsigned total;
    bit hit;
    hit = 1'b0;
    r.ev = EV_OTHER;
    r.data = 8'h00;
    r.last = 1'b1;
    case (frame_ph)
      PH_HEADER: begin
        pkt_type = b[7:4];
        rem_cnt = '0;
        len_idx = '0;
        topic_left = '0;
        drop_pkt = 1'b0;
        frame_ph = PH_LENGTH;
      end
      PH_LENGTH: begin
        rem_cnt = rem_cnt | (28'(b[6:0]) << (7 * len_idx));
        if (b[7]) begin
          if (len_idx + 1 >= MAX_LENGTH_BYTES) begin
            frame_ph = PH_HEADER;
            r.ev = EV_DROP;
            hit = 1'b1;
          end else begin
            len_idx = len_idx + 2'd1;
          end
        end else begin
          total = 2 + len_idx + rem_cnt;
          if (total > max_pkt || (pkt_type == TYPE_PUBLISH && rem_cnt < 2)) begin
            enter_skip(1'b1);
            r.ev = EV_DROP;
            hit = 1'b1;
          end else if (pkt_type == TYPE_PUBLISH) begin
            frame_ph = PH_TLEN_HI;
          end else if (rem_cnt == 0) begin
            frame_ph = PH_HEADER;
            r.ev = end_event();
            hit = 1'b1;
          end else begin
            enter_skip(1'b0);
          end
        end
      end
      PH_TLEN_HI: begin
        topic_left = {b, 8'h00};
        rem_cnt = rem_cnt - 28'd1;
        frame_ph = PH_TLEN_LO;
      end
      PH_TLEN_LO: begin
        topic_left = topic_left | {8'h00, b};
        rem_cnt = rem_cnt - 28'd1;
        if (topic_left > rem_cnt) begin
          enter_skip(1'b1);
          r.ev = EV_DROP;
          hit = 1'b1;
        end else if (topic_left != 0) begin
          frame_ph = PH_TOPIC;
        end else if (rem_cnt != 0) begin
          frame_ph = PH_PAYLOAD;
        end else begin
          frame_ph = PH_HEADER;
          hit = 1'b1;
        end
      end
      PH_TOPIC: begin
        topic_left = topic_left - 16'd1;
        rem_cnt = rem_cnt - 28'd1;
        if (topic_left == 0) begin
          if (rem_cnt == 0) frame_ph = PH_HEADER;
          else frame_ph = PH_PAYLOAD;
        end
        r.ev = EV_TOPIC;
        r.data = b;
        r.last = (rem_cnt == 0);
        hit = 1'b1;
      end
      PH_PAYLOAD: begin
        rem_cnt = rem_cnt - 28'd1;
        if (rem_cnt == 0) frame_ph = PH_HEADER;
        r.ev = EV_PAYLOAD;
        r.data = b;
        r.last = (rem_cnt == 0);
        hit = 1'b1;
      end
      PH_SKIP: begin
        rem_cnt = rem_cnt - 28'd1;
        if (rem_cnt == 0) begin
          frame_ph = PH_HEADER;
          if (drop_pkt) begin
            drop_pkt = 1'b0;
          end else begin
            r.ev = end_event();
            hit = 1'b1;
          end
        end
      end
      default: begin
        frame_ph = PH_HEADER;
      end
    endcase
    return hit;
  endfunction

  // Check results against the oldest expectation, then predict from accepted requests.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_event_res < 3'd6) ev_count[out_event_res]++;
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result ev=%0d byte=%0d last=%0d", $time,
                   out_event_res, out_out_byte, out_last);
          mismatch_count++;
        end else begin
          head_event = pending_events.pop_front();
          if (out_event_res !== head_event.ev) begin
            $display("%0t: event mismatch, expected %0d actual %0d", $time,
                     head_event.ev, out_event_res);
            mismatch_count++;
          end
          if (out_out_byte !== head_event.data) begin
            $display("%0t: byte mismatch, expected %0d actual %0d", $time,
                     head_event.data, out_out_byte);
            mismatch_count++;
          end
          if (out_last !== head_event.last) begin
            $display("%0t: last mismatch, expected %0d actual %0d", $time,
                     head_event.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        bytes_in++;
        if (frame_byte(in_data_byte, next_event)) pending_events.push_back(next_event);
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Header, remaining length in nlen bytes (may be padded), then the body.
  task automatic push_packet(input logic [7:0] hdr, input int rem, input int nlen,
                             input logic [15:0] tlen);
    push_byte(hdr);
    for (int i = 0; i < nlen; i++) push_byte({1'(i < nlen - 1), 7'(rem >> (7 * i))});
    for (int i = 0; i < rem; i++) begin
      if (hdr[7:4] == TYPE_PUBLISH && i == 0) push_byte(tlen[15:8]);
      else if (hdr[7:4] == TYPE_PUBLISH && i == 1) push_byte(tlen[7:0]);
      else push_byte(8'($urandom));
    end
  endtask

  // Shortest length encoding, sometimes padded with zero groups.
  function automatic int pick_len_bytes(input int n);
    int shortest;
    if (n < 128) shortest = 1;
    else if (n < 16384) shortest = 2;
    else if (n < 2097152) shortest = 3;
    else shortest = 4;
    if ($urandom_range(6) == 0) return $urandom_range(shortest, MAX_LENGTH_BYTES);
    return shortest;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_gap_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic apb_xfer(input bit wr, input logic [15:0] wval, output logic [15:0] rval);
    psel <= 1'b1;
    pwrite <= wr;
    penable <= 1'b0;
    paddr <= MAX_PKT_ADDR;
    pwdata <= {16'h0000, wval};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rval = prdata[15:0];
    if (wr) max_pkt = wval;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_max_packet(input logic [15:0] want);
    logic [15:0] rd;
    apb_xfer(1'b0, 16'h0000, rd);
    if (rd !== want) begin
      $display("%0t: max_packet_bytes read mismatch, expected %0d actual %0d", $time, want, rd);
      mismatch_count++;
    end
  endtask

  task automatic set_max_packet(input logic [15:0] v);
    logic [15:0] rd;
    drain();
    apb_xfer(1'b1, v, rd);
    check_max_packet(v);
  endtask

  task automatic test_register_access();
    set_idle(0, 0);
    check_max_packet(MAX_PKT_RESET);
    set_max_packet(16'd300);
    set_max_packet(MAX_PKT_RESET);
  endtask

  task automatic test_ping_and_other();
    set_idle(19, 19);
    push_packet({TYPE_PINGREQ, 4'h0}, 0, 1, 16'h0);
    push_packet({TYPE_PINGRESP, 4'hF}, 0, 1, 16'h0);
    push_packet({TYPE_PINGREQ, 4'h5}, 2, 1, 16'h0);    // body skipped, event at its end
    push_packet(8'h00, 3, 1, 16'h0);
    push_packet(8'hF0, 0, 1, 16'h0);
    push_packet({TYPE_PINGRESP, 4'h0}, 0, MAX_LENGTH_BYTES, 16'h0);  // padded zero length
    drain();
  endtask

  task automatic test_publish();
    set_idle(19, 19);
    push_packet({TYPE_PUBLISH, 4'h0}, 2 + 3 + 4, 1, 16'd3);
    push_packet({TYPE_PUBLISH, 4'hF}, 2 + 2, 1, 16'd2);  // QoS bits set, topic ends packet
    push_packet({TYPE_PUBLISH, 4'h2}, 2, 1, 16'd0);      // empty publish
    push_packet({TYPE_PUBLISH, 4'h1}, 5, 1, 16'd0);      // payload only
    push_packet({TYPE_PUBLISH, 4'h8}, 4, 2, 16'd1);
    drain();
  endtask

  task automatic test_malformed();
    set_idle(0, 0);
    // length still continuing on its last allowed byte
    push_byte({TYPE_PUBLISH, 4'h0});
    repeat (MAX_LENGTH_BYTES) push_byte(8'hFF);
    push_packet({TYPE_PUBLISH, 4'h0}, 0, 1, 16'h0);
    push_packet({TYPE_PUBLISH, 4'h0}, 1, 1, 16'h0);
    push_packet({TYPE_PUBLISH, 4'h0}, 4, 1, 16'd3);      // topic runs past the end
    push_packet({TYPE_PUBLISH, 4'h0}, 5, 1, 16'hFFFF);
    push_packet({TYPE_PUBLISH, 4'h0}, 127, 1, 16'd1);    // one byte over the default limit
    push_packet(8'h20, 127, 1, 16'h0);
    drain();
  endtask

  task automatic test_size_limits();
    set_idle(0, 0);
    set_max_packet(16'd8);
    push_packet({TYPE_PUBLISH, 4'h0}, 6, 1, 16'd1);
    push_packet({TYPE_PUBLISH, 4'h0}, 7, 1, 16'd1);
    // padded length bytes count toward the total
    set_max_packet(16'd20);
    push_packet(8'h20, 16, 3, 16'h0);                    // exactly at the limit
    push_packet(8'h20, 17, 3, 16'h0);
    set_max_packet(16'hFFFF);
    push_packet(8'h20, 10, 3, 16'h0);
    set_max_packet(MAX_PKT_RESET);
  endtask

  task automatic push_random_packet();
    int kind;
    int tlen;
    int pay;
    int rem;
    int nlen;
    logic [3:0] ptype;
    kind = $urandom_range(99);
    // keep oversized packets short enough to skip quickly
    if (kind >= 86 && kind < 92 && max_pkt > 16'd400) kind = 0;
    if (kind < 50) begin
      tlen = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      pay = ($urandom_range(9) == 0) ? $urandom_range(13, 150) : $urandom_range(0, 12);
      rem = 2 + tlen + pay;
      push_packet({TYPE_PUBLISH, 4'($urandom)}, rem, pick_len_bytes(rem), 16'(tlen));
    end else if (kind < 62) begin
      ptype = $urandom_range(1) ? TYPE_PINGREQ : TYPE_PINGRESP;
      rem = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      push_packet({ptype, 4'($urandom)}, rem, pick_len_bytes(rem), 16'h0);
    end else if (kind < 72) begin
      do ptype = 4'($urandom);
      while (ptype == TYPE_PUBLISH || ptype == TYPE_PINGREQ || ptype == TYPE_PINGRESP);
      rem = $urandom_range(0, 10);
      push_packet({ptype, 4'($urandom)}, rem, pick_len_bytes(rem), 16'h0);
    end else if (kind < 80) begin
      rem = $urandom_range(0, 8);
      tlen = (rem >= 2) ? $urandom_range(rem - 1, 300) : 0;
      push_packet({TYPE_PUBLISH, 4'($urandom)}, rem, pick_len_bytes(rem), 16'(tlen));
    end else if (kind < 86) begin
      push_byte(8'($urandom));
      repeat (MAX_LENGTH_BYTES) push_byte({1'b1, 7'($urandom)});
    end else if (kind < 92) begin
      nlen = pick_len_bytes(int'(max_pkt) + 4);
      rem = int'(max_pkt) - 1 - nlen + $urandom_range(1, 4);
      push_packet(8'($urandom), rem, nlen, 16'($urandom));
    end else begin
      push_packet(8'($urandom), $urandom_range(0, 20), 1, 16'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int target;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: set_idle(0, 0);
        1: set_idle(62, 0);
        2: set_idle(0, 62);
        default: set_idle(19, 19);
      endcase
      case (seg)
        0: set_max_packet(MAX_PKT_RESET);
        1: set_max_packet(16'd8);
        2: set_max_packet(16'hFFFF);
        5: set_max_packet(16'd8);
        default: set_max_packet(16'($urandom_range(9, 400)));
      endcase
      target = bytes_in + 48;
      while (bytes_in < target) push_random_packet();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    bytes_in = 0;
    results_seen = 0;
    mismatch_count = 0;
    foreach (ev_count[i]) ev_count[i] = 0;
    frame_ph = PH_HEADER;
    pkt_type = '0;
    rem_cnt = '0;
    len_idx = '0;
    topic_left = '0;
    drop_pkt = 1'b0;
    max_pkt = MAX_PKT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_ping_and_other();
    test_publish();
    test_malformed();
    test_size_limits();
    test_random_traffic();
    drain();

    $display("Run covered %0d stream bytes, %0d events: topic %0d, payload %0d, ping %0d/%0d,",
             bytes_in, results_seen, ev_count[EV_TOPIC], ev_count[EV_PAYLOAD],
             ev_count[EV_PINGREQ], ev_count[EV_PINGRESP]);
    $display("  dropped %0d, other %0d, under several size limits and idle patterns",
             ev_count[EV_DROP], ev_count[EV_OTHER]);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
